[sv/cert_pkg.sv]
// Package for the count extreme run tracker: field widths, register indexes,
// default parameter values and the result record type.
// No dependencies; every other file of the block imports it.
package cert_pkg;

  localparam int unsigned VAL_W      = 6;
  localparam int unsigned CNT_W      = 24;
  localparam int unsigned TOTAL_W    = 30;
  localparam int unsigned EPOCH_IN_W = 24;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam int unsigned LOW_START_DEF  = 34;
  localparam int unsigned EPOCH_BITS_DEF = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_UPPER_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWER_LIMIT = 1'b1;

  typedef struct packed {
    logic [VAL_W-1:0]   low_value;
    logic [CNT_W-1:0]   low_epochs;
    logic [CNT_W-1:0]   low_runs;
    logic [VAL_W-1:0]   high_value;
    logic [CNT_W-1:0]   high_epochs;
    logic [CNT_W-1:0]   high_runs;
    logic [CNT_W-1:0]   over_epochs;
    logic [CNT_W-1:0]   under_epochs;
    logic [TOTAL_W-1:0] count_total;
    logic [CNT_W-1:0]   epochs_seen;
  } cert_result_t;

endpackage

[sv/cert_if.sv]
// Valid/ready channel interfaces for the count extreme run tracker:
// one for input items and one for result records.
// Depends on cert_pkg.
interface cert_item_if;
  import cert_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] visible_count;
  logic [EPOCH_IN_W-1:0] epoch_index;

  modport source (output valid, output visible_count, output epoch_index, input ready);
  modport sink   (input valid, input visible_count, input epoch_index, output ready);
endinterface

interface cert_result_if;
  import cert_pkg::*;

  logic         valid;
  logic         ready;
  cert_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

[sv/count_extreme_run_tracker_core.sv]
// Count extreme run tracker: running min/max of per-epoch counts with run
// tallies, limit counters and the running sum for the average.
// Depends on cert_pkg and the channel interfaces in cert_if.sv.
//
// An accepted item is held in the input register; the statistics register then
// takes the updated record and offers it on the result channel.
// Throughput: one item per cycle while results are taken; the input register
// and the statistics register form a two-stage pipeline, so one item can wait
// in the input register while a finished result is stalled at the output.
// Reset: asynchronous, active low; all statistics and both limits return to
// their initial values and both channels go empty.
module count_extreme_run_tracker_core #(
  parameter int unsigned LOW_START  = cert_pkg::LOW_START_DEF,
  parameter int unsigned EPOCH_BITS = cert_pkg::EPOCH_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [cert_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [cert_pkg::VAL_W-1:0]        cfg_wdata_i,
  cert_item_if.sink                         item_i,
  cert_result_if.source                     result_o
);
  import cert_pkg::*;

  // Limit registers.
  logic [VAL_W-1:0] upper_q, lower_q;

  // Input stage.
  logic                  in_valid_q;
  logic [VAL_W-1:0]      cnt_q;
  logic [EPOCH_BITS-1:0] ep_q;

  // Statistics, which double as the result register.
  cert_result_t          stat_q, stat_d;
  logic [EPOCH_BITS-1:0] low_last_q, low_last_d;
  logic [EPOCH_BITS-1:0] high_last_q, high_last_d;
  logic                  out_valid_q;

  logic                  advance;
  logic                  in_accept;
  logic [TOTAL_W:0]      total_sum;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (&v) ? v : v + CNT_W'(1);
  endfunction

  assign advance   = in_valid_q && (!out_valid_q || result_o.ready);
  assign in_accept = item_i.valid && item_i.ready;

  assign item_i.ready    = !in_valid_q || advance;
  assign result_o.valid  = out_valid_q;
  assign result_o.result = stat_q;

  assign total_sum = {1'b0, stat_q.count_total} + (TOTAL_W + 1)'(cnt_q);

  always_comb begin
    stat_d      = stat_q;
    low_last_d  = low_last_q;
    high_last_d = high_last_q;

    if (cnt_q > upper_q) begin
      stat_d.over_epochs = sat_inc(stat_q.over_epochs);
    end
    if (cnt_q < lower_q) begin
      stat_d.under_epochs = sat_inc(stat_q.under_epochs);
    end

    // A run goes on only when this epoch directly follows the last one seen
    // at the same extreme.
    if (cnt_q < stat_q.low_value) begin
      stat_d.low_value  = cnt_q;
      stat_d.low_epochs = CNT_W'(1);
      stat_d.low_runs   = CNT_W'(1);
      low_last_d        = ep_q;
    end else if (cnt_q == stat_q.low_value) begin
      stat_d.low_epochs = sat_inc(stat_q.low_epochs);
      if (ep_q != low_last_q + EPOCH_BITS'(1)) begin
        stat_d.low_runs = sat_inc(stat_q.low_runs);
      end
      low_last_d = ep_q;
    end

    if (cnt_q > stat_q.high_value) begin
      stat_d.high_value  = cnt_q;
      stat_d.high_epochs = CNT_W'(1);
      stat_d.high_runs   = CNT_W'(1);
      high_last_d        = ep_q;
    end else if (cnt_q == stat_q.high_value) begin
      stat_d.high_epochs = sat_inc(stat_q.high_epochs);
      if (ep_q != high_last_q + EPOCH_BITS'(1)) begin
        stat_d.high_runs = sat_inc(stat_q.high_runs);
      end
      high_last_d = ep_q;
    end

    stat_d.count_total = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];
    stat_d.epochs_seen = sat_inc(stat_q.epochs_seen);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q <= '0;
      lower_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_UPPER_LIMIT: upper_q <= cfg_wdata_i;
        CFG_LOWER_LIMIT: lower_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cnt_q <= item_i.visible_count;
      ep_q  <= EPOCH_BITS'(item_i.epoch_index);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      stat_q      <= '{low_value: VAL_W'(LOW_START), default: '0};
      low_last_q  <= '1;
      high_last_q <= '1;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        stat_q      <= stat_d;
        low_last_q  <= low_last_d;
        high_last_q <= high_last_d;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[sv/cert_checker.sv]
// Port-level checks for the count extreme run tracker, attached to the top
// level by the bind statement at the end of this file.
// Depends on cert_pkg and count_extreme_run_tracker_core.
module cert_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input cert_pkg::cert_result_t result_i
);
  import cert_pkg::*;

  // A stalled result transaction keeps its valid and its record.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(result_i))
    else $error("stalled result changed");

  // The minimum can only fall and the maximum can only rise.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> result_i.low_value <= $past(result_i.low_value))
    else $error("low value rose");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> result_i.high_value >= $past(result_i.high_value))
    else $error("high value fell");

  // Every run holds at least one epoch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> result_i.low_runs <= result_i.low_epochs &&
                    result_i.high_runs <= result_i.high_epochs)
    else $error("more runs than epochs at an extreme");

endmodule

bind count_extreme_run_tracker_core cert_checker u_cert_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .result_i    (result_o.result)
);

[tb/sv/tb_count_extreme_run_tracker_core.sv]
`timescale 1ns / 1ps
// Testbench for count_extreme_run_tracker_core: a directed table, then random phases under
// several limit settings; results checked against table records or an in-bench statistics tracker.
// Depends on cert_pkg, the channel interfaces in cert_if.sv and the core itself.
module tb_count_extreme_run_tracker_core;
  import cert_pkg::*;

  localparam int unsigned EPOCHS_PER_PHASE = 150;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned DRAIN_CYCLES     = 8;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  typedef enum {ROW_ITEM, ROW_KNOWN, ROW_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [VAL_W-1:0]      value;
    logic [EPOCH_IN_W-1:0] epoch;
    cert_result_t          want;
  } plan_row_t;

  typedef struct packed {
    logic [VAL_W-1:0]      value;
    logic [CNT_W-1:0]      epochs;
    logic [CNT_W-1:0]      runs;
    logic [EPOCH_IN_W-1:0] last;
  } extreme_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [VAL_W-1:0]     cfg_wdata_i;

  cert_item_if   item_ch ();
  cert_result_if result_ch ();

  count_extreme_run_tracker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_ch),
    .result_o    (result_ch)
  );

  always #2 clk_i = ~clk_i;

  // Tracker state, mirroring the block's statistics and limits.
  logic [VAL_W-1:0]   upper_limit_q = '0;
  logic [VAL_W-1:0]   lower_limit_q = '0;
  extreme_t           low_q  = '{VAL_W'(LOW_START_DEF), '0, '0, '1};
  extreme_t           high_q = '{'0, '0, '0, '1};
  logic [CNT_W-1:0]   over_q  = '0;
  logic [CNT_W-1:0]   under_q = '0;
  logic [CNT_W-1:0]   seen_q  = '0;
  logic [TOTAL_W-1:0] total_q = '0;

  cert_result_t expected_stats[$];
  plan_row_t    plan[$];
  int           errors = 0;
  bit           quiet = 1'b0;
  int unsigned  cycles = 0;
  int unsigned  stall_left = 0;

  function automatic logic [CNT_W-1:0] sat_bump(logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  function automatic extreme_t track_extreme(extreme_t e, logic [VAL_W-1:0] cnt,
                                             logic [EPOCH_IN_W-1:0] ep, bit is_low);
    extreme_t n;
    n = e;
    if (is_low ? (cnt < e.value) : (cnt > e.value)) begin
      n.value  = cnt;
      n.epochs = CNT_W'(1);
      n.runs   = CNT_W'(1);
      n.last   = ep;
    end else if (cnt == e.value) begin
      n.epochs = sat_bump(e.epochs);
      // The all-ones reset of the last epoch makes epoch 0 a continuation.
      if (ep != e.last + EPOCH_IN_W'(1)) n.runs = sat_bump(e.runs);
      n.last = ep;
    end
    return n;
  endfunction

  task automatic tally_epoch(input logic [VAL_W-1:0] cnt, input logic [EPOCH_IN_W-1:0] ep,
                             output cert_result_t r);
    logic [TOTAL_W:0] sum;
    if (cnt > upper_limit_q) over_q = sat_bump(over_q);
    if (cnt < lower_limit_q) under_q = sat_bump(under_q);
    low_q  = track_extreme(low_q, cnt, ep, 1'b1);
    high_q = track_extreme(high_q, cnt, ep, 1'b0);
    sum = {1'b0, total_q} + (TOTAL_W + 1)'(cnt);
    total_q = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
    seen_q = sat_bump(seen_q);
    r.low_value    = low_q.value;
    r.low_epochs   = low_q.epochs;
    r.low_runs     = low_q.runs;
    r.high_value   = high_q.value;
    r.high_epochs  = high_q.epochs;
    r.high_runs    = high_q.runs;
    r.over_epochs  = over_q;
    r.under_epochs = under_q;
    r.count_total  = total_q;
    r.epochs_seen  = seen_q;
  endtask

  function automatic cert_result_t stats_of(int unsigned lv, int unsigned le, int unsigned lr,
                                            int unsigned hv, int unsigned he, int unsigned hr,
                                            int unsigned ov, int unsigned un, int unsigned tot,
                                            int unsigned seen);
    cert_result_t s;
    s.low_value    = VAL_W'(lv);
    s.low_epochs   = CNT_W'(le);
    s.low_runs     = CNT_W'(lr);
    s.high_value   = VAL_W'(hv);
    s.high_epochs  = CNT_W'(he);
    s.high_runs    = CNT_W'(hr);
    s.over_epochs  = CNT_W'(ov);
    s.under_epochs = CNT_W'(un);
    s.count_total  = TOTAL_W'(tot);
    s.epochs_seen  = CNT_W'(seen);
    return s;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_pause();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic send_epoch(input logic [VAL_W-1:0] cnt, input logic [EPOCH_IN_W-1:0] ep,
                            input bit use_want, input cert_result_t want);
    cert_result_t r;
    int unsigned  gap;
    item_ch.valid         <= 1'b1;
    item_ch.visible_count <= cnt;
    item_ch.epoch_index   <= ep;
    do @(posedge clk_i); while (item_ch.ready !== 1'b1);
    tally_epoch(cnt, ep, r);
    expected_stats.push_back(use_want ? want : r);
    gap = pick_pause();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Limits change only once every outstanding result has come back.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
    item_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_UPPER_LIMIT) upper_limit_q = val;
    else lower_limit_q = val;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_side
    cert_result_t want;
    cert_result_t got;
    if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = result_ch.result;
      if (expected_stats.size() == 0) begin
        $error("result transaction with no statistics expected");
        errors++;
      end else begin
        want = expected_stats.pop_front();
        check_field("low_value", TOTAL_W'(want.low_value), TOTAL_W'(got.low_value));
        check_field("low_epochs", TOTAL_W'(want.low_epochs), TOTAL_W'(got.low_epochs));
        check_field("low_runs", TOTAL_W'(want.low_runs), TOTAL_W'(got.low_runs));
        check_field("high_value", TOTAL_W'(want.high_value), TOTAL_W'(got.high_value));
        check_field("high_epochs", TOTAL_W'(want.high_epochs), TOTAL_W'(got.high_epochs));
        check_field("high_runs", TOTAL_W'(want.high_runs), TOTAL_W'(got.high_runs));
        check_field("over_epochs", TOTAL_W'(want.over_epochs), TOTAL_W'(got.over_epochs));
        check_field("under_epochs", TOTAL_W'(want.under_epochs), TOTAL_W'(got.under_epochs));
        check_field("count_total", want.count_total, got.count_total);
        check_field("epochs_seen", TOTAL_W'(want.epochs_seen), TOTAL_W'(got.epochs_seen));
      end
    end
    if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      result_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_pause();
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("count_extreme_run_tracker_core: mismatch");
      $finish;
    end
  end

  initial begin
    logic [EPOCH_IN_W-1:0] next_epoch;
    logic [VAL_W-1:0]      run_count;
    logic [VAL_W-1:0]      upper;
    logic [VAL_W-1:0]      lower;
    int unsigned           run_left;
    int unsigned           r;

    rst_ni                <= 1'b0;
    cfg_we_i              <= 1'b0;
    cfg_idx_i             <= CFG_UPPER_LIMIT;
    cfg_wdata_i           <= '0;
    item_ch.valid         <= 1'b0;
    item_ch.visible_count <= '0;
    item_ch.epoch_index   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With both limits at reset, every nonzero count is over the upper limit.
    // A count above the low start value leaves the low extreme untouched.
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd40, 24'd7,
                     stats_of(34, 0, 0, 40, 1, 1, 1, 0, 40, 1)});
    // Epoch 0 right after reset continues the run at the low start value.
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd34, 24'd0,
                     stats_of(34, 1, 0, 40, 1, 1, 2, 0, 74, 2)});
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd34, 24'd1,
                     stats_of(34, 2, 0, 40, 1, 1, 3, 0, 108, 3)});
    // A repeated epoch index opens a new run.
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd34, 24'd1,
                     stats_of(34, 3, 1, 40, 1, 1, 4, 0, 142, 4)});
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd63, 24'hFFFFFF,
                     stats_of(34, 3, 1, 63, 1, 1, 5, 0, 205, 5)});
    // The epoch index wraps from all ones to zero within one run.
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd63, 24'd0,
                     stats_of(34, 3, 1, 63, 2, 1, 6, 0, 268, 6)});
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd0, 24'h800000,
                     stats_of(0, 1, 1, 63, 2, 1, 6, 0, 268, 7)});
    plan.push_back('{ROW_KNOWN, CFG_UPPER_LIMIT, 6'd0, 24'h800002,
                     stats_of(0, 2, 2, 63, 2, 1, 6, 0, 268, 8)});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd0, 24'h800003, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd63, 24'h000001, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd33, 24'h555555, '0});
    plan.push_back('{ROW_LIMIT, CFG_UPPER_LIMIT, 6'd10, '0, '0});
    plan.push_back('{ROW_LIMIT, CFG_LOWER_LIMIT, 6'd20, '0, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd5, 24'hAAAAAA, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd10, 24'hAAAAAB, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd15, 24'h0F0F0F, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd20, 24'hF0F0F0, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd25, 24'h3C3C3C, '0});
    plan.push_back('{ROW_LIMIT, CFG_UPPER_LIMIT, 6'd63, '0, '0});
    plan.push_back('{ROW_LIMIT, CFG_LOWER_LIMIT, 6'd0, '0, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd63, 24'h123456, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd0, 24'hEDCBA9, '0});
    plan.push_back('{ROW_LIMIT, CFG_UPPER_LIMIT, 6'd0, '0, '0});
    plan.push_back('{ROW_LIMIT, CFG_LOWER_LIMIT, 6'd63, '0, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd63, 24'h000002, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd0, 24'h800004, '0});
    plan.push_back('{ROW_ITEM, CFG_UPPER_LIMIT, 6'd62, 24'hFFFFFE, '0});

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LIMIT) begin
        write_limit(plan[i].reg_idx, plan[i].value);
      end else begin
        send_epoch(plan[i].value, plan[i].epoch, plan[i].kind == ROW_KNOWN, plan[i].want);
      end
    end

    // Random part: mostly runs of consecutive epochs at one count, with stray epochs between.
    next_epoch = EPOCH_IN_W'($urandom);
    run_left   = 0;
    run_count  = '0;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          upper = 6'd63;
          lower = 6'd0;
        end
        1: begin
          upper = 6'd0;
          lower = 6'd63;
        end
        default: begin
          upper = VAL_W'($urandom_range(0, 63));
          lower = VAL_W'($urandom_range(0, 63));
        end
      endcase
      write_limit(CFG_UPPER_LIMIT, upper);
      write_limit(CFG_LOWER_LIMIT, lower);
      quiet = (p == 2);
      for (int n = 0; n < EPOCHS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_epoch(VAL_W'($urandom_range(0, 63)), EPOCH_IN_W'($urandom), 1'b0, '0);
        end else begin
          if (run_left == 0) begin
            run_left = $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            if (r < 40) run_count = low_q.value;
            else if (r < 80) run_count = high_q.value;
            else run_count = VAL_W'($urandom_range(0, 63));
            r = $urandom_range(0, 99);
            if (r < 60) next_epoch = next_epoch + EPOCH_IN_W'($urandom_range(0, 4));
            else if (r < 75) next_epoch = EPOCH_IN_W'($urandom);
            else if (r < 90) next_epoch = '1 - EPOCH_IN_W'($urandom_range(0, 2));
            else next_epoch = next_epoch - EPOCH_IN_W'(1);
          end
          send_epoch(run_count, next_epoch, 1'b0, '0);
          next_epoch = next_epoch + EPOCH_IN_W'(1);
          run_left--;
        end
      end
    end
    quiet = 1'b0;

    item_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("count_extreme_run_tracker_core: match");
    end else begin
      $display("count_extreme_run_tracker_core: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
sv/cert_pkg.sv
sv/cert_if.sv
sv/count_extreme_run_tracker_core.sv
sv/cert_checker.sv
tb/sv/tb_count_extreme_run_tracker_core.sv
